FILE: hdl/slc_pkg.sv
// Package for the set-associative LRU cache model.
// Holds the line record type, field widths and the command, outcome and register codes.
// Depends on nothing; slc_addr_split, slc_way_select and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package slc_pkg;

    // Field widths fixed by the interface.
    localparam int TAG_W   = 32;
    localparam int STAMP_W = 40;
    localparam int CNT_W   = 32;

    // Access commands.
    localparam logic [1:0] CMD_FETCH  = 2'd0;
    localparam logic [1:0] CMD_LOAD   = 2'd1;
    localparam logic [1:0] CMD_STORE  = 2'd2;
    localparam logic [1:0] CMD_MODIFY = 2'd3;

    // Outcome codes of the first lookup.
    localparam logic [1:0] OUT_HIT    = 2'd0;
    localparam logic [1:0] OUT_FILL   = 2'd1;
    localparam logic [1:0] OUT_EVICT  = 2'd2;
    localparam logic [1:0] OUT_IGNORE = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_ACTIVE_WAYS = 2'd0;
    localparam logic [1:0] REG_SET_BITS    = 2'd1;
    localparam logic [1:0] REG_BLOCK_BITS  = 2'd2;

    // One cache line as it sits in a set row of the memory.
    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } t_line;

    // Result of the way comparison for one lookup.
    typedef struct packed {
        logic hit;
        logic evict;
    } t_look_status;

endpackage

`default_nettype wire

FILE: hdl/slc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the set rows of the cache model.
`timescale 1ns / 1ps
`default_nettype none

module slc_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output      logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [0:DEPTH-1];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/slc_addr_split.sv
// Address split for the cache model: set index and tag from a byte address.
// Depends on slc_pkg for the tag width.
`timescale 1ns / 1ps
`default_nettype none

module slc_addr_split
    import slc_pkg::*;
#(
    parameter int MAX_SET_BITS = 6,
    parameter int SET_W        = 6
) (
    input  wire logic [63:0]      i_address,
    input  wire logic [2:0]       i_set_bits,
    input  wire logic [5:0]       i_block_bits,
    output      logic [SET_W-1:0] o_set,
    output      logic [TAG_W-1:0] o_tag
);

    logic [3:0]  sb_eff;
    logic [6:0]  tag_shift;
    logic [63:0] offset_dropped;

    // Clamp the set index width to what the memory holds.
    always_comb begin
        if ({1'b0, i_set_bits} > 4'(MAX_SET_BITS)) begin
            sb_eff = 4'(MAX_SET_BITS);
        end else begin
            sb_eff = {1'b0, i_set_bits};
        end
    end

    // Set index: drop the block offset, keep only the active index bits.
    assign offset_dropped = i_address >> i_block_bits;

    always_comb begin
        for (int i = 0; i < SET_W; i++) begin
            o_set[i] = offset_dropped[i] & (4'(i) < sb_eff);
        end
    end

    // Tag: drop offset and index; a shift of 64 or more leaves nothing.
    assign tag_shift = 7'(sb_eff) + 7'(i_block_bits);

    always_comb begin
        if (tag_shift >= 7'd64) begin
            o_tag = '0;
        end else begin
            o_tag = TAG_W'(i_address >> tag_shift[5:0]);
        end
    end

endmodule

`default_nettype wire

FILE: hdl/slc_way_select.sv
// Way comparison for one set row: hit search, first free way, LRU victim, updated row.
// Depends on slc_pkg for the line record and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module slc_way_select
    import slc_pkg::*;
#(
    parameter int MAX_WAYS = 8,
    parameter int WAY_W    = 3
) (
    input  wire t_line [MAX_WAYS-1:0] i_row,
    input  wire logic [TAG_W-1:0]     i_tag,
    input  wire logic [4:0]           i_ways_eff,
    input  wire logic [STAMP_W-1:0]   i_stamp,
    output      t_line [MAX_WAYS-1:0] o_row,
    output      t_look_status         o_status
);

    localparam int NW = 2 ** WAY_W;

    logic [MAX_WAYS-1:0] active;
    logic [MAX_WAYS-1:0] hit_vec;
    logic [MAX_WAYS-1:0] free_vec;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    free_way;
    logic [WAY_W-1:0]    victim_way;
    logic [WAY_W-1:0]    target;
    logic [STAMP_W-1:0]  cand_stamp [NW];
    logic                cand_ok    [NW];
    logic [WAY_W-1:0]    cand_idx   [NW];

    // Per-way flags: in use, matching, empty.
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            active[w]   = i_ways_eff > 5'(w);
            hit_vec[w]  = active[w] & i_row[w].valid & (i_row[w].tag == i_tag);
            free_vec[w] = active[w] & ~i_row[w].valid;
        end
    end

    // Lowest matching way and lowest empty way.
    always_comb begin
        hit_way  = '0;
        free_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_way = WAY_W'(w);
            end
            if (free_vec[w]) begin
                free_way = WAY_W'(w);
            end
        end
    end

    // Oldest stamp through a compare tree; the right side wins only when strictly
    // older, so ties go to the lower way.
    always_comb begin
        for (int i = 0; i < NW; i++) begin
            if (i < MAX_WAYS) begin
                cand_stamp[i] = i_row[i].stamp;
                cand_ok[i]    = active[i];
            end else begin
                cand_stamp[i] = '0;
                cand_ok[i]    = 1'b0;
            end
            cand_idx[i] = WAY_W'(i);
        end
        for (int lv = 0; lv < WAY_W; lv++) begin
            for (int i = 0; i < NW; i += (2 << lv)) begin
                if (cand_ok[i + (1 << lv)] &&
                    (!cand_ok[i] || cand_stamp[i + (1 << lv)] < cand_stamp[i])) begin
                    cand_stamp[i] = cand_stamp[i + (1 << lv)];
                    cand_ok[i]    = 1'b1;
                    cand_idx[i]   = cand_idx[i + (1 << lv)];
                end
            end
        end
        victim_way = cand_idx[0];
    end

    // Choose the way to write and build the updated row.
    always_comb begin
        o_status.hit   = |hit_vec;
        o_status.evict = ~(|hit_vec) & ~(|free_vec);
        if (|hit_vec) begin
            target = hit_way;
        end else if (|free_vec) begin
            target = free_way;
        end else begin
            target = victim_way;
        end
        o_row = i_row;
        o_row[target].valid = 1'b1;
        o_row[target].tag   = i_tag;
        o_row[target].stamp = i_stamp;
    end

endmodule

`default_nettype wire

FILE: hdl/set_assoc_lru_cache_model.sv
// Top level of the set-associative LRU cache model: control, counters, register port.
// Depends on slc_pkg, slc_ram, slc_addr_split and slc_way_select.
//
// Each accepted item (start high while busy is low) is handled as follows: in the accept
// cycle the set row is read from the row memory, and in the next cycle all ways are
// compared, the row is written back and the totals are updated. The result appears
// with o_done for one cycle after that, and a new item can be accepted in that same
// cycle; a modify does both of its lookups in the one row update. After reset the
// block clears the row memory, one set per cycle, through all 2**MAX_SET_BITS sets
// while busy stays high; register writes are taken throughout. Results cannot be
// stalled: sample them whenever o_done is high.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_cache_model
    import slc_pkg::*;
#(
    parameter int MAX_WAYS     = 8,
    parameter int MAX_SET_BITS = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // Item channel
    input  wire logic             start,
    output      logic             busy,
    input  wire logic [1:0]       i_cmd,
    input  wire logic [63:0]      i_address,
    // Result channel
    output      logic             o_done,
    output      logic [1:0]       o_outcome,
    output      logic [CNT_W-1:0] o_hit_total,
    output      logic [CNT_W-1:0] o_miss_total,
    output      logic [CNT_W-1:0] o_eviction_total,
    // Register port
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [3:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output      logic [31:0]      prdata,
    output      logic             pready
);

    localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int DEPTH  = 2 ** MAX_SET_BITS;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int LINE_W = $bits(t_line);
    localparam int ROW_W  = MAX_WAYS * LINE_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOOK  = 2'd1;
    localparam logic [1:0] ST_CLEAR = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [SET_W-1:0]   r_clr_addr;
    logic [1:0]         r_cmd;
    logic [SET_W-1:0]   r_set;
    logic [TAG_W-1:0]   r_tag;
    logic [STAMP_W-1:0] r_clock, n_clock;
    logic [CNT_W-1:0]   r_hits, n_hits;
    logic [CNT_W-1:0]   r_misses, n_misses;
    logic [CNT_W-1:0]   r_evicts, n_evicts;
    logic               r_done;
    logic [1:0]         r_outcome, n_outcome;
    logic [3:0]         r_active_ways;
    logic [2:0]         r_set_bits;
    logic [5:0]         r_block_bits;

    logic               accept;
    logic               cfg_write;
    logic               do_lookup;
    logic               is_modify;
    logic [4:0]         ways_eff;
    logic [SET_W-1:0]   split_set;
    logic [TAG_W-1:0]   split_tag;
    logic [ROW_W-1:0]   ram_rdata;
    logic [ROW_W-1:0]   new_row;
    logic               ram_we;
    logic [SET_W-1:0]   ram_waddr;
    logic [ROW_W-1:0]   ram_wdata;
    t_look_status       status;

    // Saturating add of a small increment to a running total.
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                                 input logic [1:0] inc);
        logic [CNT_W:0] sum;
        sum = {1'b0, v} + (CNT_W + 1)'(inc);
        return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    endfunction

    assign accept    = start & ~busy;
    assign busy      = (r_state != ST_IDLE);
    assign do_lookup = (r_state == ST_LOOK) && (r_cmd != CMD_FETCH);
    assign is_modify = (r_cmd == CMD_MODIFY);

    // Register port: always ready, writes on the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_ways <= 4'd1;
            r_set_bits    <= 3'd0;
            r_block_bits  <= 6'd0;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_ACTIVE_WAYS: r_active_ways <= pwdata[3:0];
                REG_SET_BITS:    r_set_bits    <= pwdata[2:0];
                REG_BLOCK_BITS:  r_block_bits  <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ACTIVE_WAYS: prdata = 32'(r_active_ways);
            REG_SET_BITS:    prdata = 32'(r_set_bits);
            REG_BLOCK_BITS:  prdata = 32'(r_block_bits);
            default:         prdata = '0;
        endcase
    end

    // Number of ways in use, clamped to the built associativity.
    always_comb begin
        if (r_active_ways == 4'd0) begin
            ways_eff = 5'd1;
        end else if ({1'b0, r_active_ways} > 5'(MAX_WAYS)) begin
            ways_eff = 5'(MAX_WAYS);
        end else begin
            ways_eff = {1'b0, r_active_ways};
        end
    end

    // Set index and tag of the incoming address.
    slc_addr_split #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .SET_W        (SET_W)
    ) u_split (
        .i_address    (i_address),
        .i_set_bits   (r_set_bits),
        .i_block_bits (r_block_bits),
        .o_set        (split_set),
        .o_tag        (split_tag)
    );

    // Row memory: one word per set holding every way's line.
    slc_ram #(
        .DATA_W (ROW_W),
        .DEPTH  (DEPTH),
        .ADDR_W (SET_W)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (split_set),
        .o_rdata (ram_rdata)
    );

    // Stamp after this item's lookups; a modify counts two.
    assign n_clock = (r_cmd == CMD_FETCH) ? r_clock :
                     (r_clock + (is_modify ? STAMP_W'(2) : STAMP_W'(1)));

    slc_way_select #(
        .MAX_WAYS (MAX_WAYS),
        .WAY_W    (WAY_W)
    ) u_ways (
        .i_row      (ram_rdata),
        .i_tag      (r_tag),
        .i_ways_eff (ways_eff),
        .i_stamp    (n_clock),
        .o_row      (new_row),
        .o_status   (status)
    );

    // Write back the updated row, or zeros during the clearing pass.
    assign ram_we    = do_lookup || (r_state == ST_CLEAR);
    assign ram_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_set;
    assign ram_wdata = (r_state == ST_CLEAR) ? '0 : new_row;

    // Totals and outcome of the lookup cycle.
    always_comb begin
        n_hits    = r_hits;
        n_misses  = r_misses;
        n_evicts  = r_evicts;
        n_outcome = OUT_IGNORE;
        if (do_lookup) begin
            if (status.hit) begin
                n_hits    = sat_add(r_hits, is_modify ? 2'd2 : 2'd1);
                n_outcome = OUT_HIT;
            end else begin
                n_hits    = sat_add(r_hits, is_modify ? 2'd1 : 2'd0);
                n_misses  = sat_add(r_misses, 2'd1);
                if (status.evict) begin
                    n_evicts  = sat_add(r_evicts, 2'd1);
                    n_outcome = OUT_EVICT;
                end else begin
                    n_outcome = OUT_FILL;
                end
            end
        end
    end

    // Sequencer: clearing pass after reset, then accept and look up.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == SET_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_clock    <= '0;
            r_hits     <= '0;
            r_misses   <= '0;
            r_evicts   <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + SET_W'(1);
            end
            r_done <= (r_state == ST_LOOK);
            if (r_state == ST_LOOK) begin
                r_clock  <= n_clock;
                r_hits   <= n_hits;
                r_misses <= n_misses;
                r_evicts <= n_evicts;
            end
        end
    end

    // Item and result payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
            r_set <= split_set;
            r_tag <= split_tag;
        end
        if (r_state == ST_LOOK) begin
            r_outcome <= n_outcome;
        end
    end

    assign o_done           = r_done;
    assign o_outcome        = r_outcome;
    assign o_hit_total      = r_hits;
    assign o_miss_total     = r_misses;
    assign o_eviction_total = r_evicts;

endmodule

`default_nettype wire

FILE: tb/tb_set_assoc_lru_cache_model.sv
// Self-checking testbench for the set-associative LRU cache model.
// Predicts every access result in SystemVerilog and compares it with the block's output.
// Depends on slc_pkg and set_assoc_lru_cache_model from the hdl folder.
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_model;
    import slc_pkg::*;

    localparam int WAYS_MAX     = 8;
    localparam int SET_BITS_MAX = 6;
    localparam int LINES        = (1 << SET_BITS_MAX) * WAYS_MAX;

    // Expected content of one result item.
    typedef struct {
        logic [1:0]  outcome;
        logic [31:0] hits;
        logic [31:0] misses;
        logic [31:0] evictions;
    } t_access_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_cmd;
    logic [63:0] i_address;
    logic        o_done;
    logic [1:0]  o_outcome;
    logic [31:0] o_hit_total;
    logic [31:0] o_miss_total;
    logic [31:0] o_eviction_total;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow copy of the cache state and the register settings.
    logic        cache_valid [LINES];
    logic [31:0] cache_tag   [LINES];
    logic [39:0] cache_stamp [LINES];
    logic [39:0] lookup_clock;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] evict_count;
    logic [3:0]  cfg_ways;
    logic [2:0]  cfg_set_bits;
    logic [5:0]  cfg_block_bits;

    t_access_result pending_results[$];
    t_access_result expected_now;
    int             err_count;
    bit             no_idle;
    logic [63:0]    addr_pool[$];

    set_assoc_lru_cache_model u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_address        (i_address),
        .o_done           (o_done),
        .o_outcome        (o_outcome),
        .o_hit_total      (o_hit_total),
        .o_miss_total     (o_miss_total),
        .o_eviction_total (o_eviction_total),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // Clock with a 2 ns period.
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // One lookup in the shadow cache; returns the outcome code and updates the state.
    function automatic logic [1:0] cache_lookup(logic [63:0] addr);
        int          ways;
        int          sb;
        int          base;
        int          pick;
        logic [63:0] set_idx;
        logic [31:0] tag;
        ways = (cfg_ways == 0) ? 1 : ((cfg_ways > WAYS_MAX) ? WAYS_MAX : int'(cfg_ways));
        sb = (cfg_set_bits > SET_BITS_MAX) ? SET_BITS_MAX : int'(cfg_set_bits);
        set_idx = (addr >> cfg_block_bits) & ((64'd1 << sb) - 64'd1);
        tag = 32'(addr >> (sb + int'(cfg_block_bits)));
        base = int'(set_idx) * WAYS_MAX;
        lookup_clock = lookup_clock + 40'd1;
        for (int w = 0; w < ways; w++) begin
            if (cache_valid[base + w] && cache_tag[base + w] == tag) begin
                cache_stamp[base + w] = lookup_clock;
                if (hit_count != '1) hit_count = hit_count + 1;
                return OUT_HIT;
            end
        end
        if (miss_count != '1) miss_count = miss_count + 1;
        for (int w = 0; w < ways; w++) begin
            if (!cache_valid[base + w]) begin
                cache_valid[base + w] = 1'b1;
                cache_tag[base + w] = tag;
                cache_stamp[base + w] = lookup_clock;
                return OUT_FILL;
            end
        end
        // Every way is valid: the oldest stamp goes, lowest way on a tie.
        pick = 0;
        for (int w = 1; w < ways; w++) begin
            if (cache_stamp[base + w] < cache_stamp[base + pick]) pick = w;
        end
        cache_tag[base + pick] = tag;
        cache_stamp[base + pick] = lookup_clock;
        if (evict_count != '1) evict_count = evict_count + 1;
        return OUT_EVICT;
    endfunction

    // Sender gap in cycles, drawn per item.
    function automatic int idle_gap();
        if (no_idle) return 0;
        return ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 12));
    endfunction

    // Drives one access item, waits for it to be taken and records what it should produce.
    task automatic send_access(logic [1:0] cmd, logic [63:0] addr);
        int             gap;
        t_access_result res;
        gap = idle_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start     <= 1'b1;
        i_cmd     <= cmd;
        i_address <= addr;
        do @(posedge i_clk); while (busy);
        res.outcome = OUT_IGNORE;
        if (cmd != CMD_FETCH) begin
            res.outcome = cache_lookup(addr);
            if (cmd == CMD_MODIFY) void'(cache_lookup(addr));
        end
        res.hits      = hit_count;
        res.misses    = miss_count;
        res.evictions = evict_count;
        pending_results.push_back(res);
    endtask

    // Lowers start and waits until every expected result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // One register write over the APB port: setup cycle, then access until pready.
    task automatic apb_write(logic [1:0] reg_idx, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Writes all three registers once the block has gone quiet.
    task automatic set_registers(logic [3:0] ways, logic [2:0] sb, logic [5:0] bb);
        drain_results();
        apb_write(REG_ACTIVE_WAYS, {28'd0, ways});
        cfg_ways = ways;
        apb_write(REG_SET_BITS, {29'd0, sb});
        cfg_set_bits = sb;
        apb_write(REG_BLOCK_BITS, {26'd0, bb});
        cfg_block_bits = bb;
    endtask

    // Accesses under the reset settings: one way, one set, no block offset.
    task automatic test_reset_settings();
        send_access(CMD_FETCH, 64'h0);
        send_access(CMD_LOAD, 64'h0);
        send_access(CMD_LOAD, '1);
        send_access(CMD_STORE, '1);
        send_access(CMD_MODIFY, 64'h0);
        send_access(CMD_FETCH, '1);
        send_access(CMD_LOAD, 64'h5555_5555_5555_5555);
    endtask

    // Four ways in one set: fill, refresh the first line, then evict in LRU order.
    task automatic test_lru_order();
        set_registers(4'd4, 3'd2, 6'd4);
        for (int t = 1; t <= 4; t++) send_access(CMD_LOAD, (64'(t) << 6) | 64'h1_3);
        send_access(CMD_LOAD, (64'd1 << 6) | 64'h1_F);
        send_access(CMD_STORE, (64'd5 << 6) | 64'h1_0);
        send_access(CMD_LOAD, (64'd2 << 6) | 64'h1_0);
        send_access(CMD_MODIFY, (64'd1 << 6) | 64'h1_8);
    endtask

    // Out-of-range way and set-bit values, and block offsets that push the tag off the top.
    task automatic test_register_extremes();
        set_registers(4'd0, 3'd7, 6'd63);
        send_access(CMD_LOAD, '1);
        send_access(CMD_LOAD, 64'h0);
        send_access(CMD_STORE, 64'h8000_0000_0000_0000);
        send_access(CMD_MODIFY, 64'h7FFF_FFFF_FFFF_FFFF);
        set_registers(4'd15, 3'd0, 6'd32);
        send_access(CMD_LOAD, 64'hFFFF_FFFF_0000_0000);
        send_access(CMD_LOAD, 64'h0000_0000_FFFF_FFFF);
        send_access(CMD_MODIFY, 64'h1234_5678_9ABC_DEF0);
    endtask

    // Builds a pool of addresses that crowd into a few sets so that hits and evictions occur.
    task automatic build_pool();
        int          sb;
        int          count;
        logic [63:0] set_mask;
        logic [63:0] base;
        sb = (cfg_set_bits > SET_BITS_MAX) ? SET_BITS_MAX : int'(cfg_set_bits);
        set_mask = ((64'd1 << sb) - 64'd1) << cfg_block_bits;
        count = $urandom_range(2, 3 * WAYS_MAX + 4);
        addr_pool.delete();
        for (int k = 0; k < count; k++) begin
            base = {$urandom, $urandom};
            base = (base & ~set_mask) | ((64'($urandom_range(0, 3)) << cfg_block_bits) & set_mask);
            addr_pool.push_back(base);
        end
    endtask

    // Random accesses over a series of register settings, extremes first.
    task automatic test_random_traffic(int phases, int per_phase);
        int          sb;
        int          done_count;
        logic [63:0] noise_mask;
        logic [63:0] addr;
        logic [1:0]  cmd;
        for (int p = 0; p < phases; p++) begin
            case (p)
                0: set_registers(4'd8, 3'd6, 6'd0);
                1: set_registers(4'd1, 3'd0, 6'd63);
                2: set_registers(4'd8, 3'd0, 6'd0);
                3: set_registers(4'd15, 3'd7, 6'd32);
                default: begin
                    set_registers(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                                  ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                              : 6'($urandom_range(0, 8)));
                end
            endcase
            no_idle = (p % 3 == 2);
            build_pool();
            sb = (cfg_set_bits > SET_BITS_MAX) ? SET_BITS_MAX : int'(cfg_set_bits);
            // Offset bits and bits above the tag do not change which line is addressed.
            noise_mask = ((64'd1 << cfg_block_bits) - 64'd1)
                       | ~((64'd1 << (int'(cfg_block_bits) + sb + 32)) - 64'd1);
            done_count = 0;
            while (done_count < per_phase) begin
                cmd = ($urandom_range(0, 11) == 0) ? CMD_FETCH : 2'($urandom_range(1, 3));
                if ($urandom_range(0, 9) == 0) begin
                    addr = {$urandom, $urandom};
                end else begin
                    addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)]
                         ^ ({$urandom, $urandom} & noise_mask);
                end
                send_access(cmd, addr);
                if (cmd != CMD_FETCH) done_count++;
            end
        end
    endtask

    // Reports one field that differs from its expectation.
    task automatic report_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
        end
    endtask

    // Every result is matched against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                err_count++;
                $display("%0t: result with no access pending, outcome %0d", $time, o_outcome);
            end else begin
                expected_now = pending_results.pop_front();
                report_field("outcome", 32'(expected_now.outcome), 32'(o_outcome));
                report_field("hit_total", expected_now.hits, o_hit_total);
                report_field("miss_total", expected_now.misses, o_miss_total);
                report_field("eviction_total", expected_now.evictions, o_eviction_total);
            end
        end
    end

    // Run limit.
    initial begin
        #600000;
        $display("set_assoc_lru_cache_model test failed");
        $finish;
    end

    // Test sequence.
    initial begin
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_cmd     = CMD_FETCH;
        i_address = 64'd0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = 4'd0;
        pwdata    = 32'd0;
        err_count = 0;
        no_idle   = 1'b0;
        for (int i = 0; i < LINES; i++) begin
            cache_valid[i] = 1'b0;
            cache_tag[i]   = '0;
            cache_stamp[i] = '0;
        end
        lookup_clock   = '0;
        hit_count      = '0;
        miss_count     = '0;
        evict_count    = '0;
        cfg_ways       = 4'd1;
        cfg_set_bits   = 3'd0;
        cfg_block_bits = 6'd0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_settings();
        test_lru_order();
        test_register_extremes();
        test_random_traffic(12, 90);
        drain_results();

        if (err_count == 0) begin
            $display("set_assoc_lru_cache_model test passed");
        end else begin
            $display("set_assoc_lru_cache_model test failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/slc_pkg.sv
hdl/slc_ram.sv
hdl/slc_addr_split.sv
hdl/slc_way_select.sv
hdl/set_assoc_lru_cache_model.sv
tb/tb_set_assoc_lru_cache_model.sv
